[rtl/fbfc_pkg.sv]
// Shared types, codes and reset constants for the filament buffer feed controller.
// Used by fbfc_core and filament_buffer_feed_controller; depends on nothing.
package fbfc_pkg;

    // Width of the millisecond clock and of all time stamps
    localparam int TIME_W = 32;

    // Widths of the stream payloads (packed fields rounded up to bytes)
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PUSH_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSES_CONT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MAX      = 3'd4;

    // Configuration reset values
    localparam logic [31:0] PUSH_TIMEOUT_RST = 32'd90000;
    localparam logic [3:0]  PRESSES_CONT_RST = 4'd2;
    localparam logic [15:0] SHORT_PRESS_RST  = 16'd150;
    localparam logic [15:0] GAP_MIN_RST      = 16'd50;
    localparam logic [15:0] GAP_MAX_RST      = 16'd500;

    // Saturation limit of a press counter
    localparam logic [3:0] PRESS_CNT_MAX = 4'd15;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_RUN_FWD  = 3'd1,
        OP_RUN_BACK = 3'd2,
        OP_HALT     = 3'd3,
        OP_RESUME   = 3'd4,
        OP_OFF      = 3'd5,
        OP_MOVE     = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        KEY_NONE = 2'd0,
        KEY_BACK = 2'd1,
        KEY_FWD  = 2'd2
    } key_t;

    typedef enum logic [2:0] {
        RPT_F    = 3'd0,
        RPT_B    = 3'd1,
        RPT_FP   = 3'd2,
        RPT_BP   = 3'd3,
        RPT_S    = 3'd4,
        RPT_T    = 3'd5,
        RPT_O    = 3'd6,
        RPT_NONE = 3'd7
    } rpt_t;

    typedef struct packed {
        logic [31:0] push_timeout_ms;
        logic [3:0]  presses_for_continuous;
        logic [15:0] short_press_ms;
        logic [15:0] press_gap_min_ms;
        logic [15:0] press_gap_max_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic        pos_low_sensor;
        logic        pos_mid_sensor;
        logic        pos_high_sensor;
        logic        filament_absent;
        logic        key_back_down;
        logic        key_fwd_down;
        logic [31:0] move_length_ms;
        logic        move_reverse;
    } item_t;

    typedef struct packed {
        logic       motor_enabled;
        logic       motor_running;
        logic       motor_forward;
        logic       filament_present;
        logic       filament_changed;
        logic [2:0] report_code;
        logic       report_new;
        logic       timed_out;
        logic       continuous_active;
    } result_t;

endpackage

[rtl/fbfc_core.sv]
// Controller state and the combinational update applied for each accepted request.
// Depends on fbfc_pkg for codes, item, configuration and result types.
module fbfc_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  fbfc_pkg::item_t  item,
    input  fbfc_pkg::cfg_t   cfg,
    output fbfc_pkg::result_t res
);

    localparam int TW = fbfc_pkg::TIME_W;

    // State registers
    logic [TW-1:0]   now_reg, now_next;
    logic [31:0]     push_elapsed_reg, push_elapsed_next;
    logic            pushing_reg, pushing_next;
    logic            timeout_reg, timeout_next;
    logic            cont_reg, cont_next;
    fbfc_pkg::dir_t  cont_dir_reg, cont_dir_next;
    logic            move_reg, move_next;
    fbfc_pkg::dir_t  move_dir_reg, move_dir_next;
    logic [TW-1:0]   move_deadline_reg, move_deadline_next;
    fbfc_pkg::dir_t  mode_reg, mode_next;
    fbfc_pkg::dir_t  prev_mode_reg, prev_mode_next;
    logic            power_reg, power_next;
    logic            spin_reg, spin_next;
    logic            fwd_reg, fwd_next;
    logic [3:0]      press_cnt_reg [2];
    logic [3:0]      press_cnt_next [2];
    logic [TW-1:0]   last_press_reg [2];
    logic [TW-1:0]   last_press_next [2];
    fbfc_pkg::key_t  held_reg, held_next;
    logic [TW-1:0]   press_start_reg, press_start_next;
    logic            wait_release_reg, wait_release_next;
    fbfc_pkg::rpt_t  last_rpt_reg, last_rpt_next;
    logic            last_presence_reg, last_presence_next;

    // Per-request temporaries
    logic            present;
    logic            changed;
    logic            status;
    logic            sent;
    logic            key_down;
    logic            kidx;
    logic            cont_hit;
    logic [TW-1:0]   gap;
    logic [TW-1:0]   dur;
    fbfc_pkg::dir_t  kdir;
    fbfc_pkg::rpt_t  cur_rpt;
    fbfc_pkg::op_t   op;

    assign op      = fbfc_pkg::op_t'(item.operation);
    assign present = !item.filament_absent;

    // Next-state update for one request, in the controller's priority order
    always_comb
    begin
        now_next           = now_reg;
        push_elapsed_next  = push_elapsed_reg;
        pushing_next       = pushing_reg;
        timeout_next       = timeout_reg;
        cont_next          = cont_reg;
        cont_dir_next      = cont_dir_reg;
        move_next          = move_reg;
        move_dir_next      = move_dir_reg;
        move_deadline_next = move_deadline_reg;
        mode_next          = mode_reg;
        prev_mode_next     = prev_mode_reg;
        power_next         = power_reg;
        spin_next          = spin_reg;
        fwd_next           = fwd_reg;
        press_cnt_next     = press_cnt_reg;
        last_press_next    = last_press_reg;
        held_next          = held_reg;
        press_start_next   = press_start_reg;
        wait_release_next  = wait_release_reg;
        last_rpt_next      = last_rpt_reg;
        last_presence_next = last_presence_reg;
        changed            = 1'b0;
        status             = 1'b1;
        sent               = 1'b0;
        key_down           = 1'b0;
        kidx               = 1'b0;
        cont_hit           = 1'b0;
        gap                = '0;
        dur                = '0;
        kdir               = fbfc_pkg::DIR_STOP;
        cur_rpt            = fbfc_pkg::RPT_S;

        // Tick: advance clock and forward push counter
        if (op == fbfc_pkg::OP_TICK)
        begin
            now_next = now_reg + TW'(1);
            if (pushing_reg)
            begin
                push_elapsed_next = push_elapsed_reg + 32'd1;
                if (push_elapsed_next > cfg.push_timeout_ms)
                    timeout_next = 1'b1;
            end
        end

        if (held_reg != fbfc_pkg::KEY_NONE)
        begin
            // Key held: only a release on a tick gets through
            key_down = (held_reg == fbfc_pkg::KEY_BACK) ? item.key_back_down
                                                        : item.key_fwd_down;
            if (op == fbfc_pkg::OP_TICK && !key_down)
            begin
                kidx     = (held_reg == fbfc_pkg::KEY_FWD);
                kdir     = kidx ? fbfc_pkg::DIR_FWD : fbfc_pkg::DIR_BACK;
                dur      = now_next - press_start_reg;
                cont_hit = (press_cnt_reg[kidx] >= cfg.presses_for_continuous);
                held_next = fbfc_pkg::KEY_NONE;
                power_next = !item.filament_absent;
                spin_next  = 1'b0;
                mode_next  = fbfc_pkg::DIR_STOP;
                pushing_next      = 1'b0;
                push_elapsed_next = '0;
                if (dur <= {{(TW-16){1'b0}}, cfg.short_press_ms} && !cont_hit)
                    timeout_next = !timeout_next;
                else
                    timeout_next = 1'b0;
                if (cont_hit)
                begin
                    cont_next            = 1'b1;
                    cont_dir_next        = kdir;
                    press_cnt_next[kidx] = '0;
                end
            end
            else
            begin
                status = 1'b0;
            end
        end
        else if (wait_release_reg)
        begin
            // After a key stopped continuous running, wait for both keys up
            if (op == fbfc_pkg::OP_TICK && !item.key_back_down && !item.key_fwd_down)
                wait_release_next = 1'b0;
            else
                status = 1'b0;
        end
        else if (op == fbfc_pkg::OP_TICK)
        begin
            if (move_reg)
            begin
                // Timed move in progress
                if (item.filament_absent)
                begin
                    power_next = 1'b0;
                    spin_next  = 1'b0;
                    mode_next  = fbfc_pkg::DIR_STOP;
                    move_next  = 1'b0;
                    if (last_rpt_next != fbfc_pkg::RPT_O)
                    begin
                        last_rpt_next = fbfc_pkg::RPT_O;
                        sent          = 1'b1;
                    end
                end
                else if (now_next >= move_deadline_reg)
                begin
                    power_next = 1'b1;
                    spin_next  = 1'b0;
                    mode_next  = fbfc_pkg::DIR_STOP;
                    move_next  = 1'b0;
                    if (last_rpt_next != fbfc_pkg::RPT_S)
                    begin
                        last_rpt_next = fbfc_pkg::RPT_S;
                        sent          = 1'b1;
                    end
                end
                else
                begin
                    power_next     = 1'b1;
                    spin_next      = 1'b1;
                    fwd_next       = (move_dir_reg == fbfc_pkg::DIR_FWD);
                    pushing_next   = (move_dir_reg == fbfc_pkg::DIR_FWD);
                    prev_mode_next = move_dir_reg;
                    mode_next      = move_dir_reg;
                    cur_rpt = (move_dir_reg == fbfc_pkg::DIR_FWD) ? fbfc_pkg::RPT_F
                                                                  : fbfc_pkg::RPT_B;
                    if (last_rpt_next != cur_rpt)
                    begin
                        last_rpt_next = cur_rpt;
                        sent          = 1'b1;
                    end
                end
            end
            else if (cont_reg)
            begin
                // Continuous running: any key or a timeout stops it
                if (item.key_back_down || item.key_fwd_down || timeout_next)
                begin
                    power_next        = 1'b1;
                    spin_next         = 1'b0;
                    mode_next         = fbfc_pkg::DIR_STOP;
                    cont_next         = 1'b0;
                    pushing_next      = 1'b0;
                    push_elapsed_next = '0;
                    timeout_next      = 1'b0;
                    if (item.key_back_down || item.key_fwd_down)
                        wait_release_next = 1'b1;
                end
                else
                begin
                    power_next     = 1'b1;
                    spin_next      = 1'b1;
                    fwd_next       = (cont_dir_reg == fbfc_pkg::DIR_FWD);
                    pushing_next   = (cont_dir_reg == fbfc_pkg::DIR_FWD);
                    prev_mode_next = cont_dir_reg;
                end
            end
            else if (item.key_back_down || item.key_fwd_down)
            begin
                // Key press: back key wins over forward key
                kidx = !item.key_back_down;
                kdir = kidx ? fbfc_pkg::DIR_FWD : fbfc_pkg::DIR_BACK;
                gap  = now_next - last_press_reg[kidx];
                if (gap >= {{(TW-16){1'b0}}, cfg.press_gap_min_ms} &&
                    gap <= {{(TW-16){1'b0}}, cfg.press_gap_max_ms})
                begin
                    if (press_cnt_reg[kidx] != fbfc_pkg::PRESS_CNT_MAX)
                        press_cnt_next[kidx] = press_cnt_reg[kidx] + 4'd1;
                end
                else
                begin
                    press_cnt_next[kidx] = 4'd1;
                end
                last_press_next[kidx] = now_next;
                power_next     = 1'b1;
                spin_next      = 1'b1;
                fwd_next       = kidx;
                prev_mode_next = kdir;
                last_rpt_next  = kidx ? fbfc_pkg::RPT_FP : fbfc_pkg::RPT_BP;
                sent           = 1'b1;
                press_start_next = now_next;
                held_next = kidx ? fbfc_pkg::KEY_FWD : fbfc_pkg::KEY_BACK;
            end
            else if (item.filament_absent)
            begin
                mode_next         = fbfc_pkg::DIR_STOP;
                pushing_next      = 1'b0;
                push_elapsed_next = '0;
                timeout_next      = 1'b0;
                cont_next         = 1'b0;
                move_next         = 1'b0;
                power_next        = 1'b0;
                spin_next         = 1'b0;
            end
            else if (timeout_next)
            begin
                mode_next  = fbfc_pkg::DIR_STOP;
                power_next = 1'b1;
                spin_next  = 1'b0;
            end
            else
            begin
                // Buffer position sensors, low has priority
                if (item.pos_low_sensor)
                begin
                    prev_mode_next = mode_reg;
                    mode_next      = fbfc_pkg::DIR_FWD;
                    pushing_next   = 1'b1;
                end
                else if (item.pos_mid_sensor)
                begin
                    prev_mode_next    = mode_reg;
                    mode_next         = fbfc_pkg::DIR_STOP;
                    pushing_next      = 1'b0;
                    push_elapsed_next = '0;
                end
                else if (item.pos_high_sensor)
                begin
                    prev_mode_next    = mode_reg;
                    mode_next         = fbfc_pkg::DIR_BACK;
                    pushing_next      = 1'b0;
                    push_elapsed_next = '0;
                end
                if (mode_next != prev_mode_next)
                begin
                    power_next = 1'b1;
                    if (mode_next == fbfc_pkg::DIR_FWD || mode_next == fbfc_pkg::DIR_BACK)
                    begin
                        spin_next = 1'b1;
                        fwd_next  = (mode_next == fbfc_pkg::DIR_FWD);
                    end
                    else
                    begin
                        spin_next = 1'b0;
                    end
                end
            end
            if (held_next != fbfc_pkg::KEY_NONE || wait_release_next)
                status = 1'b0;
        end
        else
        begin
            // Host commands
            case (op)
                fbfc_pkg::OP_RUN_FWD, fbfc_pkg::OP_RUN_BACK:
                begin
                    kdir = (op == fbfc_pkg::OP_RUN_FWD) ? fbfc_pkg::DIR_FWD
                                                        : fbfc_pkg::DIR_BACK;
                    move_next     = 1'b0;
                    cont_next     = 1'b1;
                    cont_dir_next = kdir;
                    power_next    = 1'b1;
                    spin_next     = 1'b1;
                    fwd_next      = (op == fbfc_pkg::OP_RUN_FWD);
                    mode_next     = kdir;
                    cur_rpt = (op == fbfc_pkg::OP_RUN_FWD) ? fbfc_pkg::RPT_FP
                                                           : fbfc_pkg::RPT_BP;
                    if (last_rpt_next != cur_rpt)
                    begin
                        last_rpt_next = cur_rpt;
                        sent          = 1'b1;
                    end
                end
                fbfc_pkg::OP_HALT:
                begin
                    move_next    = 1'b0;
                    timeout_next = 1'b1;
                    cont_next    = 1'b0;
                    if (last_rpt_next != fbfc_pkg::RPT_T)
                    begin
                        last_rpt_next = fbfc_pkg::RPT_T;
                        sent          = 1'b1;
                    end
                end
                fbfc_pkg::OP_RESUME, fbfc_pkg::OP_OFF:
                begin
                    move_next    = 1'b0;
                    cont_next    = 1'b0;
                    timeout_next = 1'b0;
                    mode_next    = fbfc_pkg::DIR_STOP;
                    spin_next    = 1'b0;
                    if (op == fbfc_pkg::OP_RESUME && !item.filament_absent)
                    begin
                        power_next = 1'b1;
                        cur_rpt    = fbfc_pkg::RPT_S;
                    end
                    else
                    begin
                        power_next = 1'b0;
                        cur_rpt    = fbfc_pkg::RPT_O;
                    end
                    if (last_rpt_next != cur_rpt)
                    begin
                        last_rpt_next = cur_rpt;
                        sent          = 1'b1;
                    end
                end
                fbfc_pkg::OP_MOVE:
                begin
                    kdir = item.move_reverse ? fbfc_pkg::DIR_BACK : fbfc_pkg::DIR_FWD;
                    move_next          = 1'b1;
                    cont_next          = 1'b0;
                    timeout_next       = 1'b0;
                    move_dir_next      = kdir;
                    move_deadline_next = now_next + TW'(item.move_length_ms);
                    power_next         = 1'b1;
                    spin_next          = 1'b1;
                    fwd_next           = !item.move_reverse;
                    mode_next          = kdir;
                    cur_rpt = item.move_reverse ? fbfc_pkg::RPT_B : fbfc_pkg::RPT_F;
                    if (last_rpt_next != cur_rpt)
                    begin
                        last_rpt_next = cur_rpt;
                        sent          = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Status pass: filament presence, then the current movement report
        if (status)
        begin
            if (present != last_presence_reg)
            begin
                changed            = 1'b1;
                last_presence_next = present;
                if (!present)
                begin
                    power_next = 1'b0;
                    spin_next  = 1'b0;
                    cont_next  = 1'b0;
                    move_next  = 1'b0;
                    if (last_rpt_next != fbfc_pkg::RPT_O)
                    begin
                        last_rpt_next = fbfc_pkg::RPT_O;
                        sent          = 1'b1;
                    end
                end
            end
            if (!power_next)
                cur_rpt = fbfc_pkg::RPT_O;
            else if (timeout_next)
                cur_rpt = fbfc_pkg::RPT_T;
            else if (cont_next)
                cur_rpt = (cont_dir_next == fbfc_pkg::DIR_FWD) ? fbfc_pkg::RPT_FP
                                                               : fbfc_pkg::RPT_BP;
            else if (mode_next == fbfc_pkg::DIR_FWD)
                cur_rpt = fbfc_pkg::RPT_F;
            else if (mode_next == fbfc_pkg::DIR_BACK)
                cur_rpt = fbfc_pkg::RPT_B;
            else
                cur_rpt = fbfc_pkg::RPT_S;
            if (last_rpt_next != cur_rpt)
            begin
                last_rpt_next = cur_rpt;
                sent          = 1'b1;
            end
        end
    end

    // Result for this request, taken from the updated state
    always_comb
    begin
        res.motor_enabled     = power_next;
        res.motor_running     = spin_next;
        res.motor_forward     = spin_next && fwd_next;
        res.filament_present  = present;
        res.filament_changed  = changed;
        res.report_code       = (last_rpt_next == fbfc_pkg::RPT_NONE) ? fbfc_pkg::RPT_S
                                                                      : last_rpt_next;
        res.report_new        = sent;
        res.timed_out         = timeout_next;
        res.continuous_active = cont_next;
    end

    // State update on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg           <= '0;
            push_elapsed_reg  <= '0;
            pushing_reg       <= 1'b0;
            timeout_reg       <= 1'b0;
            cont_reg          <= 1'b0;
            cont_dir_reg      <= fbfc_pkg::DIR_STOP;
            move_reg          <= 1'b0;
            move_dir_reg      <= fbfc_pkg::DIR_STOP;
            move_deadline_reg <= '0;
            mode_reg          <= fbfc_pkg::DIR_STOP;
            prev_mode_reg     <= fbfc_pkg::DIR_STOP;
            power_reg         <= 1'b1;
            spin_reg          <= 1'b0;
            fwd_reg           <= 1'b0;
            press_cnt_reg[0]  <= '0;
            press_cnt_reg[1]  <= '0;
            last_press_reg[0] <= '0;
            last_press_reg[1] <= '0;
            held_reg          <= fbfc_pkg::KEY_NONE;
            press_start_reg   <= '0;
            wait_release_reg  <= 1'b0;
            last_rpt_reg      <= fbfc_pkg::RPT_NONE;
            last_presence_reg <= 1'b1;
        end
        else if (accept)
        begin
            now_reg           <= now_next;
            push_elapsed_reg  <= push_elapsed_next;
            pushing_reg       <= pushing_next;
            timeout_reg       <= timeout_next;
            cont_reg          <= cont_next;
            cont_dir_reg      <= cont_dir_next;
            move_reg          <= move_next;
            move_dir_reg      <= move_dir_next;
            move_deadline_reg <= move_deadline_next;
            mode_reg          <= mode_next;
            prev_mode_reg     <= prev_mode_next;
            power_reg         <= power_next;
            spin_reg          <= spin_next;
            fwd_reg           <= fwd_next;
            press_cnt_reg     <= press_cnt_next;
            last_press_reg    <= last_press_next;
            held_reg          <= held_next;
            press_start_reg   <= press_start_next;
            wait_release_reg  <= wait_release_next;
            last_rpt_reg      <= last_rpt_next;
            last_presence_reg <= last_presence_next;
        end
    end

    // A held key and the wait after continuous stop never overlap
    a_hold_wait_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(held_reg != fbfc_pkg::KEY_NONE && wait_release_reg))
        else $error("key hold and release wait both active");

    // Continuous running and a timed move never overlap
    a_cont_move_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cont_reg && move_reg))
        else $error("continuous run and timed move both active");

    // Continuous running always has a real direction
    a_cont_dir: assert property (@(posedge clk) disable iff (!rst_n)
        cont_reg |-> (cont_dir_reg == fbfc_pkg::DIR_FWD || cont_dir_reg == fbfc_pkg::DIR_BACK))
        else $error("continuous run without direction");

    // The state only moves on an accepted request
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(now_reg) && $stable(last_rpt_reg))
        else $error("state changed without a request");

endmodule

[rtl/filament_buffer_feed_controller.sv]
// Filament buffer feed controller: stream handshake, configuration registers
// and the result register around fbfc_core. Depends on fbfc_pkg and fbfc_core.
//
// Usage:
//  - Input stream (s_t*): one request per millisecond tick with the sampled
//    sensors and keys, or a host command (run, halt, resume, off, move).
//  - Output stream (m_t*): exactly one result per request, in order: motor
//    enable/run/direction, filament presence and change, report code and
//    whether it is new, timeout and continuous-run flags.
//  - Configuration: cfg_wr_en writes cfg_data into register cfg_index in the
//    same clock; write only while no request is in flight.
// Timing: an accepted request's result appears in the output register on the
// next cycle. One request per cycle is sustained while m_tready stays high;
// the whole update is a single combinational pass between the state registers
// and the result register.
// Reset: all state cleared, motor power on, no report sent yet; the
// configuration registers return to their defaults.
// Stall: while the result register holds an untaken result and m_tready is
// low, s_tready is low; the result is held stable until taken.
module filament_buffer_feed_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: operation[2:0], pos_low_sensor[3], pos_mid_sensor[4],
    // pos_high_sensor[5], filament_absent[6], key_back_down[7],
    // key_fwd_down[8], move_length_ms[40:9], move_reverse[41], zero[47:42]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fbfc_pkg::IN_DATA_W-1:0]      s_tdata,
    // m_tdata: motor_enabled[0], motor_running[1], motor_forward[2],
    // filament_present[3], filament_changed[4], report_code[7:5],
    // report_new[8], timed_out[9], continuous_active[10], zero[15:11]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fbfc_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [fbfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    fbfc_pkg::cfg_t    cfg_reg;
    fbfc_pkg::item_t   item;
    fbfc_pkg::result_t res;
    logic [fbfc_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic              out_valid_reg;
    logic              accept;

    // Handshake: take a request whenever the result register is free or draining
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Unpack the request
    always_comb
    begin
        item.operation       = s_tdata[2:0];
        item.pos_low_sensor  = s_tdata[3];
        item.pos_mid_sensor  = s_tdata[4];
        item.pos_high_sensor = s_tdata[5];
        item.filament_absent = s_tdata[6];
        item.key_back_down   = s_tdata[7];
        item.key_fwd_down    = s_tdata[8];
        item.move_length_ms  = s_tdata[40:9];
        item.move_reverse    = s_tdata[41];
    end

    fbfc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .res    (res)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.push_timeout_ms        <= fbfc_pkg::PUSH_TIMEOUT_RST;
            cfg_reg.presses_for_continuous <= fbfc_pkg::PRESSES_CONT_RST;
            cfg_reg.short_press_ms         <= fbfc_pkg::SHORT_PRESS_RST;
            cfg_reg.press_gap_min_ms       <= fbfc_pkg::GAP_MIN_RST;
            cfg_reg.press_gap_max_ms       <= fbfc_pkg::GAP_MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                fbfc_pkg::CFG_PUSH_TIMEOUT: cfg_reg.push_timeout_ms        <= cfg_data;
                fbfc_pkg::CFG_PRESSES_CONT: cfg_reg.presses_for_continuous <= cfg_data[3:0];
                fbfc_pkg::CFG_SHORT_PRESS:  cfg_reg.short_press_ms         <= cfg_data[15:0];
                fbfc_pkg::CFG_GAP_MIN:      cfg_reg.press_gap_min_ms       <= cfg_data[15:0];
                fbfc_pkg::CFG_GAP_MAX:      cfg_reg.press_gap_max_ms       <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {5'b0, res.continuous_active, res.timed_out, res.report_new,
                             res.report_code, res.filament_changed, res.filament_present,
                             res.motor_forward, res.motor_running, res.motor_enabled};
        end
    end

    // A stalled result blocks new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !s_tready)
        else $error("request taken while result stalled");

    // Every accepted request leaves a result pending in the next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request produced no result");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for filament_buffer_feed_controller: directed and random
// tick/command requests against a cycle-free behavioral predictor of the feed logic.
// Depends on fbfc_pkg and the filament_buffer_feed_controller RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fbfc_pkg::*;

    // Cycles with no handshake on either side before the run is declared hung
    localparam int STALL_LIMIT = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    filament_buffer_feed_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor: configuration copy and controller state
    // ---------------------------------------------------------------
    logic [31:0] cf_timeout = PUSH_TIMEOUT_RST;
    logic [3:0]  cf_presses = PRESSES_CONT_RST;
    logic [15:0] cf_short   = SHORT_PRESS_RST;
    logic [15:0] cf_gap_min = GAP_MIN_RST;
    logic [15:0] cf_gap_max = GAP_MAX_RST;

    logic [31:0] ms_now = '0;
    logic [31:0] push_ms = '0;
    logic [31:0] move_end = '0;
    logic [31:0] hold_from = '0;
    logic [31:0] press_stamp [2] = '{32'd0, 32'd0};
    logic [3:0]  press_cnt [2] = '{4'd0, 4'd0};
    bit          pushing = 1'b0;
    bit          tmo = 1'b0;
    bit          cont_on = 1'b0;
    bit          move_on = 1'b0;
    bit          power = 1'b1;
    bit          await_keys = 1'b0;
    bit          presence_seen = 1'b1;
    dir_t        cont_dir = DIR_STOP;
    dir_t        move_dir = DIR_STOP;
    dir_t        mode = DIR_STOP;
    dir_t        prev_mode = DIR_STOP;
    key_t        held = KEY_NONE;
    rpt_t        last_rpt = RPT_NONE;
    bit          spin = 1'b0;
    bit          spin_fwd = 1'b0;
    bit          rpt_sent = 1'b0;

    // Scoreboard and stimulus bookkeeping
    result_t     expected_status [$];
    item_t       offered;
    int          mismatches = 0;
    int          sent_items = 0;
    int          quiet_cycles = 0;
    int          rx_hold = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;

    function automatic void drive_run(dir_t d);
        power    = 1'b1;
        spin     = 1'b1;
        spin_fwd = (d == DIR_FWD);
    endfunction

    function automatic void drive_hold();
        power = 1'b1;
        spin  = 1'b0;
    endfunction

    function automatic void drive_off();
        power = 1'b0;
        spin  = 1'b0;
    endfunction

    // Reports go out only when the code changes
    function automatic void send_report(rpt_t r);
        if (r != last_rpt)
        begin
            last_rpt = r;
            rpt_sent = 1'b1;
        end
    endfunction

    function automatic rpt_t status_code();
        if (!power)
            return RPT_O;
        if (tmo)
            return RPT_T;
        if (cont_on)
            return (cont_dir == DIR_FWD) ? RPT_FP : RPT_BP;
        if (mode == DIR_FWD)
            return RPT_F;
        if (mode == DIR_BACK)
            return RPT_B;
        return RPT_S;
    endfunction

    function automatic void stop_push();
        pushing = 1'b0;
        push_ms = '0;
    endfunction

    // Key press: count multi-press sequence, spin, wait for release
    function automatic void key_down(bit k, dir_t d);
        logic [31:0] gap;
        gap = ms_now - press_stamp[k];
        if (gap >= cf_gap_min && gap <= cf_gap_max)
        begin
            if (press_cnt[k] < PRESS_CNT_MAX)
                press_cnt[k]++;
        end
        else
            press_cnt[k] = 4'd1;
        press_stamp[k] = ms_now;
        drive_run(d);
        prev_mode = d;
        last_rpt  = RPT_NONE;
        send_report((d == DIR_FWD) ? RPT_FP : RPT_BP);
        hold_from = ms_now;
        held = k ? KEY_FWD : KEY_BACK;
    endfunction

    // Expected result of one request; updates the predictor state
    function automatic result_t predict_feed(item_t it);
        result_t     r;
        bit          tick, present, changed, show, down, k, cont;
        dir_t        d;
        logic [31:0] dur;
        tick     = (it.operation == OP_TICK);
        present  = !it.filament_absent;
        changed  = 1'b0;
        show     = 1'b1;
        rpt_sent = 1'b0;

        // Millisecond clock and forward push time
        if (tick)
        begin
            ms_now++;
            if (pushing)
            begin
                push_ms++;
                if (push_ms > cf_timeout)
                    tmo = 1'b1;
            end
        end

        if (held != KEY_NONE)
        begin
            // Key held: only its release on a tick ends the wait
            down = (held == KEY_BACK) ? it.key_back_down : it.key_fwd_down;
            if (tick && !down)
            begin
                k    = (held == KEY_FWD);
                d    = k ? DIR_FWD : DIR_BACK;
                dur  = ms_now - hold_from;
                cont = (press_cnt[k] >= cf_presses);
                held = KEY_NONE;
                if (it.filament_absent)
                    drive_off();
                else
                    drive_hold();
                mode = DIR_STOP;
                stop_push();
                if (dur <= cf_short && !cont)
                    tmo = !tmo;
                else
                    tmo = 1'b0;
                if (cont)
                begin
                    cont_on      = 1'b1;
                    cont_dir     = d;
                    press_cnt[k] = 4'd0;
                end
            end
            else
                show = 1'b0;
        end
        else if (await_keys)
        begin
            // After a key stopped continuous running, wait for both keys up
            if (tick && !it.key_back_down && !it.key_fwd_down)
                await_keys = 1'b0;
            else
                show = 1'b0;
        end
        else if (tick)
        begin
            // Tick control in priority order
            if (move_on)
            begin
                if (it.filament_absent)
                begin
                    drive_off();
                    mode = DIR_STOP;
                    send_report(RPT_O);
                    move_on = 1'b0;
                end
                else if (ms_now >= move_end)
                begin
                    drive_hold();
                    mode = DIR_STOP;
                    send_report(RPT_S);
                    move_on = 1'b0;
                end
                else
                begin
                    drive_run(move_dir);
                    pushing   = (move_dir == DIR_FWD);
                    prev_mode = move_dir;
                    mode      = move_dir;
                    send_report((move_dir == DIR_FWD) ? RPT_F : RPT_B);
                end
            end
            else if (cont_on)
            begin
                if (it.key_back_down || it.key_fwd_down || tmo)
                begin
                    drive_hold();
                    mode    = DIR_STOP;
                    cont_on = 1'b0;
                    stop_push();
                    tmo = 1'b0;
                    if (it.key_back_down || it.key_fwd_down)
                        await_keys = 1'b1;
                end
                else
                begin
                    drive_run(cont_dir);
                    pushing   = (cont_dir == DIR_FWD);
                    prev_mode = cont_dir;
                end
            end
            else if (it.key_back_down)
                key_down(1'b0, DIR_BACK);
            else if (it.key_fwd_down)
                key_down(1'b1, DIR_FWD);
            else if (it.filament_absent)
            begin
                mode = DIR_STOP;
                stop_push();
                tmo     = 1'b0;
                cont_on = 1'b0;
                move_on = 1'b0;
                drive_off();
            end
            else if (tmo)
            begin
                mode = DIR_STOP;
                drive_hold();
            end
            else
            begin
                // Buffer position sensors
                if (it.pos_low_sensor)
                begin
                    prev_mode = mode;
                    mode      = DIR_FWD;
                    pushing   = 1'b1;
                end
                else if (it.pos_mid_sensor)
                begin
                    prev_mode = mode;
                    mode      = DIR_STOP;
                    stop_push();
                end
                else if (it.pos_high_sensor)
                begin
                    prev_mode = mode;
                    mode      = DIR_BACK;
                    stop_push();
                end
                if (mode != prev_mode)
                begin
                    if (mode == DIR_FWD || mode == DIR_BACK)
                        drive_run(mode);
                    else
                        drive_hold();
                end
            end
            if (held != KEY_NONE || await_keys)
                show = 1'b0;
        end
        else
        begin
            // Host commands
            case (it.operation)
                OP_RUN_FWD, OP_RUN_BACK:
                begin
                    d = (it.operation == OP_RUN_FWD) ? DIR_FWD : DIR_BACK;
                    move_on  = 1'b0;
                    cont_on  = 1'b1;
                    cont_dir = d;
                    drive_run(d);
                    mode = d;
                    send_report((d == DIR_FWD) ? RPT_FP : RPT_BP);
                end
                OP_HALT:
                begin
                    move_on = 1'b0;
                    tmo     = 1'b1;
                    cont_on = 1'b0;
                    send_report(RPT_T);
                end
                OP_RESUME, OP_OFF:
                begin
                    move_on = 1'b0;
                    cont_on = 1'b0;
                    tmo     = 1'b0;
                    mode    = DIR_STOP;
                    if (it.operation == OP_RESUME && !it.filament_absent)
                    begin
                        drive_hold();
                        send_report(RPT_S);
                    end
                    else
                    begin
                        drive_off();
                        send_report(RPT_O);
                    end
                end
                OP_MOVE:
                begin
                    move_on  = 1'b1;
                    cont_on  = 1'b0;
                    tmo      = 1'b0;
                    move_dir = it.move_reverse ? DIR_BACK : DIR_FWD;
                    move_end = ms_now + it.move_length_ms;
                    drive_run(move_dir);
                    mode = move_dir;
                    send_report((move_dir == DIR_FWD) ? RPT_F : RPT_B);
                end
                default:
                begin
                end
            endcase
        end

        // Status pass: filament presence, then the current report
        if (show)
        begin
            if (present != presence_seen)
            begin
                changed       = 1'b1;
                presence_seen = present;
                if (!present)
                begin
                    drive_off();
                    cont_on = 1'b0;
                    move_on = 1'b0;
                    send_report(RPT_O);
                end
            end
            send_report(status_code());
        end

        r.motor_enabled     = power;
        r.motor_running     = spin;
        r.motor_forward     = spin && spin_fwd;
        r.filament_present  = present;
        r.filament_changed  = changed;
        r.report_code       = (last_rpt == RPT_NONE) ? RPT_S : last_rpt;
        r.report_new        = rpt_sent;
        r.timed_out         = tmo;
        r.continuous_active = cont_on;
        return r;
    endfunction

    function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Scoreboard: results checked first, then new requests predicted
    // ---------------------------------------------------------------
    initial
    begin : scoreboard
        result_t want;
        forever
        begin
            @(posedge clk);
            quiet_cycles++;
            if (rst_n && m_tvalid && m_tready)
            begin
                quiet_cycles = 0;
                if (expected_status.size() == 0)
                begin
                    $error("result arrived with no request outstanding: %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("motor_enabled", want.motor_enabled, m_tdata[0]);
                    check_field("motor_running", want.motor_running, m_tdata[1]);
                    check_field("motor_forward", want.motor_forward, m_tdata[2]);
                    check_field("filament_present", want.filament_present, m_tdata[3]);
                    check_field("filament_changed", want.filament_changed, m_tdata[4]);
                    check_field("report_code", want.report_code, m_tdata[7:5]);
                    check_field("report_new", want.report_new, m_tdata[8]);
                    check_field("timed_out", want.timed_out, m_tdata[9]);
                    check_field("continuous_active", want.continuous_active, m_tdata[10]);
                end
            end
            if (rst_n && s_tvalid && s_tready)
            begin
                quiet_cycles = 0;
                expected_status.push_back(predict_feed(offered));
            end
        end
    end

    // Watchdog on handshake activity
    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stall bursts plus an optional long hold-off
    initial
    begin : receiver
        int burst;
        burst = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                m_tready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Request driving
    // ---------------------------------------------------------------
    task automatic send_request(input item_t it);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        offered  <= it;
        s_tdata  <= {6'd0, it.move_reverse, it.move_length_ms, it.key_fwd_down,
                     it.key_back_down, it.filament_absent, it.pos_high_sensor,
                     it.pos_mid_sensor, it.pos_low_sensor, it.operation};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sent_items++;
    endtask

    // Tick with sampled sensors; unused move fields carry random bits
    task automatic send_tick(bit lo, bit mid, bit hi, bit absent, bit kb, bit kf);
        item_t it;
        it.operation       = OP_TICK;
        it.pos_low_sensor  = lo;
        it.pos_mid_sensor  = mid;
        it.pos_high_sensor = hi;
        it.filament_absent = absent;
        it.key_back_down   = kb;
        it.key_fwd_down    = kf;
        it.move_length_ms  = $urandom;
        it.move_reverse    = $urandom_range(0, 1);
        send_request(it);
    endtask

    // Host command; sensor and key bits are don't-care and randomized
    task automatic send_cmd(op_t op, bit absent, logic [31:0] len, bit rev);
        item_t it;
        it.operation       = op;
        it.pos_low_sensor  = $urandom_range(0, 1);
        it.pos_mid_sensor  = $urandom_range(0, 1);
        it.pos_high_sensor = $urandom_range(0, 1);
        it.filament_absent = absent;
        it.key_back_down   = $urandom_range(0, 1);
        it.key_fwd_down    = $urandom_range(0, 1);
        it.move_length_ms  = len;
        it.move_reverse    = rev;
        send_request(it);
    endtask

    // Stop offering and wait until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_PUSH_TIMEOUT: cf_timeout = val;
            CFG_PRESSES_CONT: cf_presses = val[3:0];
            CFG_SHORT_PRESS:  cf_short   = val[15:0];
            CFG_GAP_MIN:      cf_gap_min = val[15:0];
            CFG_GAP_MAX:      cf_gap_max = val[15:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic load_settings(logic [31:0] timeout, logic [3:0] presses,
                                 logic [15:0] short_ms, logic [15:0] gap_min,
                                 logic [15:0] gap_max);
        drain();
        write_reg(CFG_PUSH_TIMEOUT, timeout);
        write_reg(CFG_PRESSES_CONT, {28'd0, presses});
        write_reg(CFG_SHORT_PRESS, {16'd0, short_ms});
        write_reg(CFG_GAP_MIN, {16'd0, gap_min});
        write_reg(CFG_GAP_MAX, {16'd0, gap_max});
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] rand_length();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Random episodes
    // ---------------------------------------------------------------
    task automatic sensor_run();
        repeat ($urandom_range(1, 12))
            send_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 19) == 0, 1'b0, 1'b0);
    endtask

    // One or more presses of one key with random hold and gap lengths
    task automatic key_sequence();
        bit fwd_key;
        fwd_key = $urandom_range(0, 1);
        repeat ($urandom_range(1, 4))
        begin
            repeat ($urandom_range(1, 6))
                send_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                          $urandom_range(0, 19) == 0,
                          !fwd_key || $urandom_range(0, 9) == 0,
                          fwd_key || $urandom_range(0, 9) == 0);
            repeat ($urandom_range(1, 10))
                send_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                          $urandom_range(0, 29) == 0, 1'b0, 1'b0);
        end
    endtask

    task automatic host_command();
        send_cmd(op_t'($urandom_range(1, 6)), $urandom_range(0, 9) == 0, rand_length(),
                 $urandom_range(0, 1));
        if ($urandom_range(0, 1))
            sensor_run();
    endtask

    task automatic noise_item();
        item_t it;
        it = {3'(op_t'($urandom_range(0, 6))), 6'($urandom), 32'($urandom),
              1'($urandom)};
        send_request(it);
    endtask

    task automatic random_episode();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            sensor_run();
        else if (pick < 65)
            key_sequence();
        else if (pick < 85)
            host_command();
        else
            noise_item();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset settings: sensors, every command, move extremes, key handling
    task automatic test_directed_ops();
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // continuous run stopped by a key, then wait for release
        send_cmd(OP_RUN_FWD, 1'b0, 32'd0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        send_cmd(OP_HALT, 1'b0, 32'd0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_cmd(OP_RUN_BACK, 1'b0, 32'hFFFF_FFFF, 1'b1);
        send_cmd(OP_HALT, 1'b0, 32'd0, 1'b0);
        send_cmd(OP_RESUME, 1'b0, 32'd0, 1'b0);
        send_cmd(OP_OFF, 1'b0, 32'd0, 1'b0);
        send_cmd(OP_RESUME, 1'b1, 32'd0, 1'b0);
        // moves: zero length, wrapping deadline, cut short by missing filament
        send_cmd(OP_MOVE, 1'b0, 32'd0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_cmd(OP_MOVE, 1'b0, 32'hFFFF_FFFF, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_cmd(OP_MOVE, 1'b0, 32'd5, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        // held key: commands ignored until release
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        send_cmd(OP_OFF, 1'b0, 32'd0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_random_phase(logic [31:0] timeout, logic [3:0] presses,
                                     logic [15:0] short_ms, logic [15:0] gap_min,
                                     logic [15:0] gap_max, int count);
        int stop_at;
        load_settings(timeout, presses, short_ms, gap_min, gap_max);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        stop_at = sent_items + count;
        while (sent_items < stop_at)
            random_episode();
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        load_settings(32'd40, 4'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tx_idle_en = 1'b0;
        rx_hold = 300;
        repeat (6)
            sensor_run();
        tx_idle_en = 1'b1;
    endtask

    // Back-to-back requests with the receiver always ready
    task automatic test_quiet_tail();
        int stop_at;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        stop_at = sent_items + 150;
        while (sent_items < stop_at)
            random_episode();
    endtask

    initial
    begin : main
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_random_phase(32'd20, 4'd2, 16'd3, 16'd2, 16'd10, 300);
        test_random_phase(32'd0, 4'd1, 16'd0, 16'd0, 16'd0, 200);
        test_random_phase(32'hFFFF_FFFF, 4'd9, 16'hFFFF, 16'd0, 16'hFFFF, 250);
        test_random_phase(32'd7, 4'd3, 16'd5, 16'd1, 16'd12, 250);
        test_random_phase($urandom_range(0, 60), $urandom_range(1, 4), $urandom_range(0, 8),
                          $urandom_range(0, 4), $urandom_range(0, 16), 200);
        test_backpressure();
        test_quiet_tail();
        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
